// ===== design/shp_pkg.sv =====
// Shared constants, codes and types of the 3x3 sharpen filter.
package shp_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int MAX_CHANNELS_DEF = 4;

  localparam int SAMPLE_W     = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int CHAN_REG_W   = 3;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 2;

  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int RESET_CHANNELS = 3;
  localparam int MIN_WIDTH      = 3;
  localparam int MIN_HEIGHT     = 3;

  localparam int SHARPEN_GAIN = 5;
  localparam int ACC_W        = 12;
  localparam int OUTQ_DEPTH   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_DRAIN  = 1'b1
  } op_t;

  // Per-item decisions made at accept time, carried down the pipeline.
  typedef struct packed {
    logic shift;   // sample enters line stores and window
    logic emit;    // item produces one result beat
    logic border;  // result pixel lies on the image border
    logic last;    // result is the final one of the frame
  } shp_ctl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pixel;
    logic                last;
  } shp_beat_t;

endpackage

// ===== design/shp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module shp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/shp_seq.sv =====
// Configuration registers and raster position sequencer of the sharpen filter.
module shp_seq #(
  parameter int MAX_WIDTH    = shp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CHANNELS = shp_pkg::MAX_CHANNELS_DEF,
  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_CHANNELS),
  localparam int CW     = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_acc,
  input  logic                            item_op,
  output shp_pkg::shp_ctl_t               ctl,
  output logic [ADDR_W-1:0]               rd_addr,
  output logic [CW-1:0]                   chan
);
  import shp_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int RL_W  = $clog2(MAX_WIDTH * MAX_CHANNELS + 1);
  localparam int DW    = $clog2((MAX_WIDTH + 1) * MAX_CHANNELS + 1);

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [CHAN_REG_W-1:0]   chan_r;

  logic [ADDR_W-1:0]       in_k_r, in_k_nxt;
  logic [HEIGHT_REG_W-1:0] in_row_r, in_row_nxt;
  logic                    in_done_r, in_done_nxt;
  logic [DW-1:0]           diff_r, diff_nxt;
  logic [CW-1:0]           oc_ch_r, oc_ch_nxt;
  logic [COL_W-1:0]        oc_col_r, oc_col_nxt;
  logic [HEIGHT_REG_W-1:0] oc_row_r, oc_row_nxt;

  logic [WW-1:0]           w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [CW-1:0]           c_eff;
  logic [RL_W-1:0]         row_len;
  logic [DW-1:0]           lag;
  logic                    take, emit, cfg_hit;
  logic                    k_wrap, in_row_last;
  logic                    ch_wrap, col_wrap, row_last_out, frame_end, border;

  // Clamp the registers to their usable ranges.
  always_comb begin
    if (width_r < WIDTH_REG_W'(MIN_WIDTH)) begin
      w_eff = WW'(MIN_WIDTH);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r < HEIGHT_REG_W'(MIN_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MIN_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    if (chan_r == '0) begin
      c_eff = CW'(1);
    end else if (32'(chan_r) > MAX_CHANNELS) begin
      c_eff = CW'(MAX_CHANNELS);
    end else begin
      c_eff = CW'(chan_r);
    end
  end

  assign row_len = RL_W'(w_eff) * RL_W'(c_eff);
  assign lag     = DW'(row_len) + DW'(c_eff);

  assign k_wrap       = (RL_W'(in_k_r) == row_len - RL_W'(1));
  assign in_row_last  = (in_row_r == h_eff - 1'b1);
  assign ch_wrap      = (oc_ch_r == c_eff - 1'b1);
  assign col_wrap     = (WW'(oc_col_r) == w_eff - 1'b1);
  assign row_last_out = (oc_row_r == h_eff - 1'b1);
  assign frame_end    = ch_wrap && col_wrap && row_last_out;
  assign border       = (oc_row_r == '0) || row_last_out || (oc_col_r == '0) || col_wrap;

  assign cfg_hit = cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT
                              || cfg_index == CFG_CHANNEL_COUNT);

  always_comb begin
    // A sample past the end of the frame input acts as a drain.
    take = (op_t'(item_op) == OP_SAMPLE) && !in_done_r;
    emit = take ? (diff_r >= lag) : in_done_r;

    in_k_nxt    = in_k_r;
    in_row_nxt  = in_row_r;
    in_done_nxt = in_done_r;
    diff_nxt    = diff_r;
    oc_ch_nxt   = oc_ch_r;
    oc_col_nxt  = oc_col_r;
    oc_row_nxt  = oc_row_r;

    if (take) begin
      if (k_wrap) begin
        in_k_nxt = '0;
        if (in_row_last) begin
          in_done_nxt = 1'b1;
        end else begin
          in_row_nxt = in_row_r + 1'b1;
        end
      end else begin
        in_k_nxt = in_k_r + 1'b1;
      end
    end

    if (take && !emit) begin
      diff_nxt = diff_r + 1'b1;
    end else if (!take && emit) begin
      diff_nxt = diff_r - 1'b1;
    end

    if (emit) begin
      if (frame_end) begin
        // Final result: restart both sides of the frame.
        in_k_nxt    = '0;
        in_row_nxt  = '0;
        in_done_nxt = 1'b0;
        diff_nxt    = '0;
        oc_ch_nxt   = '0;
        oc_col_nxt  = '0;
        oc_row_nxt  = '0;
      end else if (ch_wrap) begin
        oc_ch_nxt = '0;
        if (col_wrap) begin
          oc_col_nxt = '0;
          oc_row_nxt = oc_row_r + 1'b1;
        end else begin
          oc_col_nxt = oc_col_r + 1'b1;
        end
      end else begin
        oc_ch_nxt = oc_ch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_REG_W'(RESET_WIDTH);
      height_r  <= HEIGHT_REG_W'(RESET_HEIGHT);
      chan_r    <= CHAN_REG_W'(RESET_CHANNELS);
      in_k_r    <= '0;
      in_row_r  <= '0;
      in_done_r <= 1'b0;
      diff_r    <= '0;
      oc_ch_r   <= '0;
      oc_col_r  <= '0;
      oc_row_r  <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:   width_r  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_FRAME_HEIGHT:  height_r <= cfg_data[HEIGHT_REG_W-1:0];
        CFG_CHANNEL_COUNT: chan_r   <= cfg_data[CHAN_REG_W-1:0];
        default: ;
      endcase
      in_k_r    <= '0;
      in_row_r  <= '0;
      in_done_r <= 1'b0;
      diff_r    <= '0;
      oc_ch_r   <= '0;
      oc_col_r  <= '0;
      oc_row_r  <= '0;
    end else if (item_acc) begin
      in_k_r    <= in_k_nxt;
      in_row_r  <= in_row_nxt;
      in_done_r <= in_done_nxt;
      diff_r    <= diff_nxt;
      oc_ch_r   <= oc_ch_nxt;
      oc_col_r  <= oc_col_nxt;
      oc_row_r  <= oc_row_nxt;
    end
  end

  assign ctl     = '{shift: take, emit: emit, border: border, last: frame_end};
  assign rd_addr = in_k_r;
  assign chan    = c_eff;

  a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n) diff_r <= lag)
    else $error("input leads output by more than one row plus one pixel");

  a_done_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_done_r |-> (in_k_r == '0 && in_row_last))
    else $error("frame input marked complete away from the frame end");

endmodule

// ===== design/shp_window.sv =====
// Neighbour window shift lines and the saturating sharpen kernel.
module shp_window #(
  parameter int MAX_CHANNELS = shp_pkg::MAX_CHANNELS_DEF,
  localparam int CW = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [shp_pkg::SAMPLE_W-1:0] up_in,
  input  logic [shp_pkg::SAMPLE_W-1:0] mid_in,
  input  logic [shp_pkg::SAMPLE_W-1:0] low_in,
  input  logic [CW-1:0]                chan,
  input  logic                         border,
  output logic [shp_pkg::SAMPLE_W-1:0] pixel
);
  import shp_pkg::*;

  localparam int MID_LEN = 2 * MAX_CHANNELS + 1;
  localparam int MI_W    = $clog2(MID_LEN);

  // Upper and lower rows only feed the centre column, so they stop there.
  logic [SAMPLE_W-1:0] up_r  [MAX_CHANNELS+1];
  logic [SAMPLE_W-1:0] mid_r [MID_LEN];
  logic [SAMPLE_W-1:0] low_r [MAX_CHANNELS+1];

  logic [SAMPLE_W-1:0] centre, left_s, right_s, above, below;
  logic [ACC_W-1:0]    acc;

  always_ff @(posedge clk) begin
    if (shift) begin
      up_r[0]  <= up_in;
      mid_r[0] <= mid_in;
      low_r[0] <= low_in;
      for (int i = 1; i <= MAX_CHANNELS; i++) begin
        up_r[i]  <= up_r[i-1];
        low_r[i] <= low_r[i-1];
      end
      for (int i = 1; i < MID_LEN; i++) begin
        mid_r[i] <= mid_r[i-1];
      end
    end
  end

  always_comb begin
    centre  = mid_r[MI_W'(chan)];
    left_s  = mid_r[MI_W'({chan, 1'b0})];
    right_s = mid_r[0];
    above   = up_r[chan];
    below   = low_r[chan];
    acc = ACC_W'(SHARPEN_GAIN) * ACC_W'(centre) - ACC_W'(left_s) - ACC_W'(right_s)
          - ACC_W'(above) - ACC_W'(below);
    // Clamp to 0..255: top bit is the sign of the two's complement sum.
    if (border || acc[ACC_W-1]) begin
      pixel = '0;
    end else if (acc[ACC_W-2:SAMPLE_W] != '0) begin
      pixel = '1;
    end else begin
      pixel = acc[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== design/shp_outq.sv =====
// Result queue with slot reservation that paces the input side.
module shp_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 reserve,
  input  logic                 rel,
  input  logic                 push,
  input  shp_pkg::shp_beat_t   push_beat,
  input  logic                 out_ready,
  output logic                 has_room,
  output logic                 out_valid,
  output shp_pkg::shp_beat_t   head
);
  import shp_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam int RW = $clog2(OUTQ_DEPTH + 1);

  shp_beat_t       q_r [OUTQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [RW-1:0]   fill_r, rsv_r;
  logic            pop;

  assign out_valid = (fill_r != '0);
  assign pop       = out_valid && out_ready;
  assign has_room  = (rsv_r < RW'(OUTQ_DEPTH));
  assign head      = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      rsv_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + RW'(push) - RW'(pop);
      rsv_r  <= rsv_r + RW'(reserve) - RW'(rel) - RW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fill_r < RW'(OUTQ_DEPTH))
    else $error("result pushed into a full queue");

  a_fill_reserved: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= rsv_r)
    else $error("queued beats exceed reserved slots");

endmodule

// ===== design/sharpen_3x3_laplacian_filter_top.sv =====
// Top level of the 3x3 sharpen filter: pipeline, line store RAMs and port wiring.
// Throughput: one beat per cycle in, one result beat per cycle out, sustained while out_tready is high.
// Path: a result leaves on out_* after the input beat that causes it has passed the RAM read,
//   window shift and kernel, and result queue; it belongs to the pixel one row plus one
//   pixel behind that beat. A four-beat result queue absorbs out_tready stalls.
// Reset: synchronous on rst_n low; clears counters, pipeline valids and queue, loads
//   register defaults. Line stores and window are not swept: no interior result reads
//   an entry before the current frame has written it.
module sharpen_3x3_laplacian_filter_top #(
  parameter int MAX_WIDTH    = shp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CHANNELS = shp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] sample
  input  logic                            in_tuser,   // [0] op: 0 sample, 1 drain
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] pixel_out
  output logic                            out_tlast,  // frame_last
  // configuration
  input  logic                            cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import shp_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_CHANNELS + 1);

  logic                in_acc;
  shp_ctl_t            ctl;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CW-1:0]       chan;
  logic                rd_en;

  // stage 1: line store data returns, write back and window shift
  logic                s1_vld_r;
  shp_ctl_t            s1_ctl_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                s1_wr;
  logic [SAMPLE_W-1:0] up_rdata, mid_rdata;

  // stage 2: kernel on the shifted window, result into the queue
  logic                s2_vld_r;
  shp_ctl_t            s2_ctl_r;
  logic [SAMPLE_W-1:0] pixel;
  shp_beat_t           push_beat, head;
  logic                has_room;

  assign in_acc = in_tvalid && in_tready;
  // Hold the input whenever every queue slot is spoken for by beats in flight.
  assign in_tready = has_room;

  shp_seq #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item_acc (in_acc),
    .item_op  (in_tuser),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .chan     (chan)
  );

  // Read both stores only for beats that enter the window.
  assign rd_en = in_acc && ctl.shift;
  // Write back in the cycle after the read. Successive beats touch distinct columns and a
  // row is at least three beats long, so a column is never read while its write pends.
  assign s1_wr = s1_vld_r && s1_ctl_r.shift;

  // Upper store takes over the middle row; middle store takes the new sample.
  shp_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_upper_ram (
    .clk  (clk),
    .we   (s1_wr),
    .waddr(s1_addr_r),
    .wdata(mid_rdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(up_rdata)
  );

  shp_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_middle_ram (
    .clk  (clk),
    .we   (s1_wr),
    .waddr(s1_addr_r),
    .wdata(s1_sample_r),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(mid_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r    <= ctl;
    s1_addr_r   <= rd_addr;
    s1_sample_r <= in_tdata;
    s2_ctl_r    <= s1_ctl_r;
  end

  shp_window #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_window (
    .clk   (clk),
    .shift (s1_wr),
    .up_in (up_rdata),
    .mid_in(mid_rdata),
    .low_in(s1_sample_r),
    .chan  (chan),
    .border(s2_ctl_r.border),
    .pixel (pixel)
  );

  assign push_beat = '{pixel: pixel, last: s2_ctl_r.last};

  // Beats that yield no result drop their queue slot at stage 2.
  shp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .reserve  (in_acc),
    .rel      (s2_vld_r && !s2_ctl_r.emit),
    .push     (s2_vld_r && s2_ctl_r.emit),
    .push_beat(push_beat),
    .out_ready(out_tready),
    .has_room (has_room),
    .out_valid(out_tvalid),
    .head     (head)
  );

  assign out_tdata = head.pixel;
  assign out_tlast = head.last;

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_wr && rd_en) |-> (s1_addr_r != rd_addr))
    else $error("line store read hits a column with a pending write");

  a_drain_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ctl.shift) |-> (in_tuser == OP_SAMPLE))
    else $error("drain beat shifted into the window");

endmodule
